@@ hdl/mhp_pkg.sv @@
`timescale 1ns / 1ps

package mhp_pkg;

  // Field widths that the item formats fix.
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned STATUS_W = 2;

  // Operation codes of an input item.
  typedef enum logic [0:0] {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  // Status codes of a result item.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  // Input item.
  typedef struct packed {
    op_t                       operation;
    logic signed [DATA_W-1:0]  value;
  } in_item_t;

  // Result item.
  typedef struct packed {
    status_t                   status;
    logic [COUNT_W-1:0]        count;
    logic signed [DATA_W-1:0]  min_value;
  } out_item_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_SRCH_UP,
    S_LAST_GET,
    S_SD_RDL,
    S_SD_RDR,
    S_SD_CMP,
    S_SU_RD,
    S_SU_CMP,
    S_DONE
  } state_t;

endpackage

@@ hdl/mhp_ram.sv @@
`timescale 1ns / 1ps

module mhp_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic                              clk,
  input  logic                              we,
  input  logic [AW-1:0]                     waddr,
  input  logic signed [mhp_pkg::DATA_W-1:0] wdata,
  input  logic                              re,
  input  logic [AW-1:0]                     raddr,
  output logic signed [mhp_pkg::DATA_W-1:0] rdata
);

  logic signed [mhp_pkg::DATA_W-1:0] mem [DEPTH];

  // Single write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Single read port with registered data.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/min_heap_insert_remove.sv @@
`timescale 1ns / 1ps

// Binary min-heap of signed 32-bit keys held in a single-port-read, single-port-write
// RAM of CAPACITY entries, with one result item for every input item giving the status,
// the new entry count and the current minimum. All work is paced by the one RAM read
// port. An insert climbs level by level, reading each parent and comparing. A remove
// visits the nodes of a pruned pre-order search, reading and comparing each and moving
// to a sibling or a parent, then sifts down (reading the left child, the right child,
// then comparing) or sifts up. A full insert and a remove from an empty heap go
// straight to the result; a remove that finds nothing, or that hits the last entry,
// ends after its search with no sift. One item is processed at a time; a new item is
// taken while the previous result still waits on the output register.
module min_heap_insert_remove #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  mhp_pkg::in_item_t    in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output mhp_pkg::out_item_t   out_item
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned XW = AW + 2;
  localparam int unsigned DW = mhp_pkg::DATA_W;
  localparam int unsigned OW = mhp_pkg::COUNT_W;

  mhp_pkg::state_t         state_r, state_nxt;
  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic [AW-1:0]           idx_r, idx_nxt;
  logic signed [DW-1:0]    val_r, val_nxt;
  logic signed [DW-1:0]    lv_r, lv_nxt;
  logic                    moved_r, moved_nxt;
  mhp_pkg::status_t        status_r, status_nxt;
  logic signed [DW-1:0]    root_r;
  logic                    out_valid_r;
  mhp_pkg::out_item_t      out_item_r;

  // RAM port signals.
  logic                    we;
  logic [AW-1:0]           waddr;
  logic signed [DW-1:0]    wdata;
  logic                    re;
  logic [AW-1:0]           raddr;
  logic signed [DW-1:0]    rdata;

  // Tree index arithmetic, widened so children past the end can be compared.
  logic [XW-1:0]           cnt_x, left_x, right_x, sib_x;
  logic [AW-1:0]           parent;
  logic [CW-1:0]           cnt_dec;
  logic                    left_ok, right_ok;
  logic                    go_right;
  logic                    take_out;
  logic [CW+OW-1:0]        cnt_ext;

  assign cnt_x    = XW'(cnt_r);
  assign left_x   = (XW'(idx_r) << 1) + XW'(1);
  assign right_x  = left_x + XW'(1);
  assign sib_x    = XW'(idx_r) + XW'(1);
  assign parent   = (idx_r - AW'(1)) >> 1;
  assign cnt_dec  = cnt_r - CW'(1);
  assign left_ok  = left_x < cnt_x;
  assign right_ok = right_x < cnt_x;
  // Equal children send the key to the right child.
  assign go_right = right_ok && !(lv_r < rdata);
  assign take_out = !out_valid_r || out_ready;

  mhp_ram #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // State and control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mhp_pkg::S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (state_r == mhp_pkg::S_DONE && take_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working registers of the current item.
  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    val_r    <= val_nxt;
    lv_r     <= lv_nxt;
    moved_r  <= moved_nxt;
    status_r <= status_nxt;
  end

  // Shadow of the root entry, kept in step with every write to slot zero.
  always_ff @(posedge clk) begin
    if (we && waddr == '0) begin
      root_r <= wdata;
    end
  end

  // Result register.
  assign cnt_ext = CW'(cnt_r) | (CW + OW)'(0);
  always_ff @(posedge clk) begin
    if (state_r == mhp_pkg::S_DONE && take_out) begin
      out_item_r.status    <= status_r;
      out_item_r.count     <= cnt_ext[OW-1:0];
      out_item_r.min_value <= (cnt_r != '0) ? root_r : '0;
    end
  end

  assign in_ready  = (state_r == mhp_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Sequencer: search, sift-down and sift-up over the RAM. The key being sifted
  // stays in val_r and is written only where it comes to rest.
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    idx_nxt    = idx_r;
    val_nxt    = val_r;
    lv_nxt     = lv_r;
    moved_nxt  = moved_r;
    status_nxt = status_r;
    we         = 1'b0;
    waddr      = idx_r;
    wdata      = val_r;
    re         = 1'b0;
    raddr      = idx_r;

    unique case (state_r)
      mhp_pkg::S_IDLE: begin
        if (in_valid) begin
          val_nxt    = in_item.value;
          status_nxt = mhp_pkg::ST_OK;
          if (in_item.operation == mhp_pkg::OP_INSERT) begin
            if (cnt_r == CW'(CAPACITY)) begin
              status_nxt = mhp_pkg::ST_FULL;
              state_nxt  = mhp_pkg::S_DONE;
            end else begin
              idx_nxt   = AW'(cnt_r);
              cnt_nxt   = cnt_r + CW'(1);
              state_nxt = mhp_pkg::S_SU_RD;
            end
          end else if (cnt_r == '0) begin
            status_nxt = mhp_pkg::ST_NOT_FOUND;
            state_nxt  = mhp_pkg::S_DONE;
          end else begin
            idx_nxt   = '0;
            state_nxt = mhp_pkg::S_SRCH_RD;
          end
        end
      end

      // Fetch the node under inspection.
      mhp_pkg::S_SRCH_RD: begin
        re        = 1'b1;
        raddr     = idx_r;
        state_nxt = mhp_pkg::S_SRCH_CMP;
      end

      // Match, descend to the left child, or back out of this subtree.
      mhp_pkg::S_SRCH_CMP: begin
        if (rdata == val_r) begin
          cnt_nxt = cnt_dec;
          if (CW'(idx_r) == cnt_dec) begin
            state_nxt = mhp_pkg::S_DONE;
          end else begin
            re        = 1'b1;
            raddr     = AW'(cnt_dec);
            state_nxt = mhp_pkg::S_LAST_GET;
          end
        end else if (val_r > rdata && left_ok) begin
          idx_nxt   = AW'(left_x);
          state_nxt = mhp_pkg::S_SRCH_RD;
        end else begin
          state_nxt = mhp_pkg::S_SRCH_UP;
        end
      end

      // Move to the next pre-order node: a right sibling, or up a level.
      mhp_pkg::S_SRCH_UP: begin
        if (idx_r == '0) begin
          status_nxt = mhp_pkg::ST_NOT_FOUND;
          state_nxt  = mhp_pkg::S_DONE;
        end else if (idx_r[0] && sib_x < cnt_x) begin
          idx_nxt   = AW'(sib_x);
          state_nxt = mhp_pkg::S_SRCH_RD;
        end else begin
          idx_nxt = parent;
        end
      end

      // The last entry moves into the freed slot.
      mhp_pkg::S_LAST_GET: begin
        val_nxt   = rdata;
        moved_nxt = 1'b0;
        state_nxt = mhp_pkg::S_SD_RDL;
      end

      // Sift-down: fetch the left child, or stop at a leaf.
      mhp_pkg::S_SD_RDL: begin
        if (left_ok) begin
          re        = 1'b1;
          raddr     = AW'(left_x);
          state_nxt = mhp_pkg::S_SD_RDR;
        end else if (moved_r) begin
          we        = 1'b1;
          state_nxt = mhp_pkg::S_DONE;
        end else begin
          state_nxt = mhp_pkg::S_SU_RD;
        end
      end

      // Sift-down: hold the left child and fetch the right one.
      mhp_pkg::S_SD_RDR: begin
        lv_nxt = rdata;
        if (right_ok) begin
          re    = 1'b1;
          raddr = AW'(right_x);
        end
        state_nxt = mhp_pkg::S_SD_CMP;
      end

      // Sift-down: pull the smaller child up if it beats the key.
      mhp_pkg::S_SD_CMP: begin
        if (val_r > lv_r || (right_ok && val_r > rdata)) begin
          we        = 1'b1;
          waddr     = idx_r;
          wdata     = go_right ? rdata : lv_r;
          idx_nxt   = go_right ? AW'(right_x) : AW'(left_x);
          moved_nxt = 1'b1;
          state_nxt = mhp_pkg::S_SD_RDL;
        end else if (moved_r) begin
          we        = 1'b1;
          state_nxt = mhp_pkg::S_DONE;
        end else begin
          state_nxt = mhp_pkg::S_SU_RD;
        end
      end

      // Sift-up: fetch the parent, or settle at the root.
      mhp_pkg::S_SU_RD: begin
        if (idx_r == '0) begin
          we        = 1'b1;
          state_nxt = mhp_pkg::S_DONE;
        end else begin
          re        = 1'b1;
          raddr     = parent;
          state_nxt = mhp_pkg::S_SU_CMP;
        end
      end

      // Sift-up: pull the parent down if the key is smaller.
      mhp_pkg::S_SU_CMP: begin
        we = 1'b1;
        if (val_r < rdata) begin
          wdata     = rdata;
          idx_nxt   = parent;
          state_nxt = mhp_pkg::S_SU_RD;
        end else begin
          state_nxt = mhp_pkg::S_DONE;
        end
      end

      // Wait for the result register to free up.
      mhp_pkg::S_DONE: begin
        if (take_out) begin
          state_nxt = mhp_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = mhp_pkg::S_IDLE;
      end
    endcase
  end

endmodule
